// ----- sv/bilinear_image_downscaler_assert.svh -----
// Assertion macros for the bilinear image downscaler.
`ifndef BILINEAR_IMAGE_DOWNSCALER_ASSERT_SVH
`define BILINEAR_IMAGE_DOWNSCALER_ASSERT_SVH

`ifndef SYNTH
`define BIDS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("downscaler assertion failed");
`define BIDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("downscaler assertion failed");
`else
`define BIDS_ASSERT_IMPL(label, ante, cons)
`define BIDS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/bids_pkg.sv -----
// Shared constants and register codes for the bilinear image downscaler.
`default_nettype none

package bids_pkg;

	localparam int MAX_WIDTH_DEF = 8192;
	localparam int FRAC_BITS_DEF = 16;
	localparam int HEIGHT_CAP    = 8192;

	localparam int SIZE_W  = 14;
	localparam int STEP_W  = 30;
	localparam int ROW_W   = 13;
	localparam int PIX_W   = 8;
	localparam int COORD_W = 13;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_X_STEP     = 3'd4,
		REG_Y_STEP     = 3'd5
	} reg_idx_t;

	localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = 14'd3;
	localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = 14'd3;
	localparam logic [SIZE_W-1:0] DST_WIDTH_RST  = 14'd1;
	localparam logic [SIZE_W-1:0] DST_HEIGHT_RST = 14'd1;
	localparam logic [STEP_W-1:0] X_STEP_RST     = 30'd196608;
	localparam logic [STEP_W-1:0] Y_STEP_RST     = 30'd196608;

endpackage

`default_nettype wire

// ----- sv/bilinear_image_downscaler.sv -----
// Streaming bilinear grayscale downscaler with a line store and one shared MAC unit.
// A source beat with no result keeps in_ready low from its accept through S_GX, S_GY, S_WB1 and S_WB2.
// Each result takes six multiply-accumulate steps (S_M0 to S_M5) on one shared
// (FRAC_BITS+1) x (FRAC_BITS+8) multiplier plus the output load in S_PUT; up to 4 results a beat.
// Gathering walks one coordinate step per cycle, taking at most two destination indices per axis.
// Reset clears counters, accumulators and config to defaults; the line store is not cleared.
`default_nettype none

module bilinear_image_downscaler import bids_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PIX_W-1:0]   src_pixel,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [PIX_W-1:0]   out_pixel,
	output logic      [COORD_W-1:0] out_x,
	output logic      [COORD_W-1:0] out_y,
	output logic                    run_last,
	output logic                    frame_end
);

	`include "bilinear_image_downscaler_assert.svh"

	localparam int SZ_W  = $clog2(MAX_WIDTH + 1);
	localparam int IDX_W = $clog2(MAX_WIDTH);
	localparam int GI_W  = (SZ_W > SIZE_W) ? SZ_W : SIZE_W;
	localparam int ACC_W = ((GI_W + FRAC_BITS > STEP_W) ? GI_W + FRAC_BITS : STEP_W) + 2;
	localparam int INT_W = ACC_W - FRAC_BITS;
	localparam int W_W   = FRAC_BITS + 1;
	localparam int X_W   = PIX_W + FRAC_BITS;
	localparam int MAC_W = 2 * FRAC_BITS + PIX_W;
	localparam int P_W   = W_W + X_W;

	localparam logic [W_W-1:0]    ONE_W    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [STEP_W-1:0] STEP_ONE = {{(STEP_W-FRAC_BITS-1){1'b0}}, 1'b1,
		{FRAC_BITS{1'b0}}};
	localparam logic [MAC_W-1:0]  HALF     = {{PIX_W{1'b0}}, 1'b1, {(2*FRAC_BITS-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_GX, S_GY, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_PUT, S_WB1, S_WB2
	} state_t;

	// config registers
	logic [SIZE_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [STEP_W-1:0] x_step_q, y_step_q;
	logic              cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			dst_width_q  <= DST_WIDTH_RST;
			dst_height_q <= DST_HEIGHT_RST;
			x_step_q     <= X_STEP_RST;
			y_step_q     <= Y_STEP_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_SRC_WIDTH:  src_width_q  <= pwdata[SIZE_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[SIZE_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= pwdata[SIZE_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= pwdata[SIZE_W-1:0];
				REG_X_STEP:     x_step_q     <= pwdata[STEP_W-1:0];
				REG_Y_STEP:     y_step_q     <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_SRC_WIDTH:  prdata = DATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = DATA_W'(src_height_q);
			REG_DST_WIDTH:  prdata = DATA_W'(dst_width_q);
			REG_DST_HEIGHT: prdata = DATA_W'(dst_height_q);
			REG_X_STEP:     prdata = DATA_W'(x_step_q);
			REG_Y_STEP:     prdata = DATA_W'(y_step_q);
			default:        prdata = '0;
		endcase
	end

	// effective sizes and steps
	logic [GI_W-1:0]   sw, sw_m1, dw_c, dw;
	logic [SIZE_W-1:0] sh, sh_m1, dh_c, dh;
	logic [STEP_W-1:0] xs, ys;

	always_comb begin
		if (src_width_q == '0)
			sw = GI_W'(1);
		else if (GI_W'(src_width_q) > GI_W'(MAX_WIDTH))
			sw = GI_W'(MAX_WIDTH);
		else
			sw = GI_W'(src_width_q);
		if (dst_width_q == '0)
			dw_c = GI_W'(1);
		else if (GI_W'(dst_width_q) > GI_W'(MAX_WIDTH))
			dw_c = GI_W'(MAX_WIDTH);
		else
			dw_c = GI_W'(dst_width_q);
		dw = (dw_c > sw) ? sw : dw_c;
		if (src_height_q == '0)
			sh = SIZE_W'(1);
		else if (src_height_q > SIZE_W'(HEIGHT_CAP))
			sh = SIZE_W'(HEIGHT_CAP);
		else
			sh = src_height_q;
		if (dst_height_q == '0)
			dh_c = SIZE_W'(1);
		else if (dst_height_q > SIZE_W'(HEIGHT_CAP))
			dh_c = SIZE_W'(HEIGHT_CAP);
		else
			dh_c = dst_height_q;
		dh = (dh_c > sh) ? sh : dh_c;
		sw_m1 = sw - GI_W'(1);
		sh_m1 = sh - SIZE_W'(1);
		xs = (x_step_q < STEP_ONE) ? STEP_ONE : x_step_q;
		ys = (y_step_q < STEP_ONE) ? STEP_ONE : y_step_q;
	end

	// position state
	state_t            state_q;
	logic [IDX_W-1:0]  src_col_q, c_q, c_comb, c_left;
	logic [ROW_W-1:0]  src_row_q, r_q, r_comb;
	logic [SZ_W-1:0]   dst_col_q;
	logic [SIZE_W-1:0] dst_row_q;
	logic [ACC_W-1:0]  x_accum_q, y_accum_q;
	logic [PIX_W-1:0]  cur_left_q, pix_q, up_here_q, up_left_q;
	logic              col_last_q, row_last_q, in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign c_comb   = (GI_W'(src_col_q) < sw) ? src_col_q : sw_m1[IDX_W-1:0];
	assign c_left   = c_comb - IDX_W'(1);
	assign r_comb   = (SIZE_W'(src_row_q) < sh) ? src_row_q : sh_m1[ROW_W-1:0];

	// line store
	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [PIX_W-1:0] mem_wdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = c_q;
		mem_wdata = pix_q;
		if (state_q == S_WB1) begin
			mem_we    = (c_q != '0);
			mem_waddr = c_q - IDX_W'(1);
			mem_wdata = cur_left_q;
		end else if (state_q == S_WB2) begin
			mem_we = col_last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[mem_waddr] <= mem_wdata;
		if (in_fire) begin
			up_here_q <= line_mem[c_comb];
			up_left_q <= line_mem[c_left];
		end
	end

	// shared coordinate walker
	logic [ACC_W-1:0]     g_acc_q, g_step;
	logic [GI_W-1:0]      g_idx_q, g_size, g_pos, g_dsize, g_last, g_hi;
	logic [1:0]           g_n_q, ncol_q, nrow_q;
	logic [INT_W-1:0]     g_int;
	logic [FRAC_BITS-1:0] g_frac;
	logic                 g_clamp, g_take, g_x;

	assign g_x     = (state_q == S_GX);
	assign g_size  = g_x ? sw : GI_W'(sh);
	assign g_pos   = g_x ? GI_W'(c_q) : GI_W'(r_q);
	assign g_dsize = g_x ? dw : GI_W'(dh);
	assign g_step  = ACC_W'(g_x ? xs : ys);
	assign g_last  = g_size - GI_W'(1);
	assign g_int   = g_acc_q[ACC_W-1:FRAC_BITS];
	assign g_clamp = (g_int >= INT_W'(g_last));
	assign g_hi    = g_clamp ? g_last : (g_int[GI_W-1:0] + GI_W'(1));
	assign g_frac  = g_clamp ? '0 : g_acc_q[FRAC_BITS-1:0];
	assign g_take  = (g_n_q != 2'd2) && (g_idx_q < g_dsize) && (g_hi == g_pos);

	logic [GI_W-1:0]      col_idx_q [2];
	logic [GI_W-1:0]      row_idx_q [2];
	logic [FRAC_BITS-1:0] fx_q [2];
	logic [FRAC_BITS-1:0] fy_q [2];
	logic [1:0]           cl_q, ru_q;
	logic                 i_q, j_q;

	// blend datapath
	logic [FRAC_BITS-1:0] fx, fy;
	logic                 cl, ru, c_nz, r_nz, last_pair;
	logic [PIX_W-1:0]     left_cur, here_up, left_up, tl, tr, p00, p10;
	logic [W_W-1:0]       mul_w;
	logic [X_W-1:0]       mul_x, a_q, b_q;
	logic [P_W-1:0]       prod;
	logic [MAC_W-1:0]     mac_q, rnd;

	always_comb begin
		fx       = fx_q[j_q];
		cl       = cl_q[j_q];
		fy       = fy_q[i_q];
		ru       = ru_q[i_q];
		c_nz     = (c_q != '0);
		r_nz     = (r_q != '0);
		left_cur = c_nz ? cur_left_q : pix_q;
		here_up  = r_nz ? up_here_q : pix_q;
		left_up  = c_nz ? (r_nz ? up_left_q : cur_left_q) : here_up;
		tl       = ru ? left_up : left_cur;
		tr       = ru ? here_up : pix_q;
		p00      = cl ? tl : tr;
		p10      = cl ? left_cur : pix_q;
		case (state_q)
			S_M0: begin
				mul_w = ONE_W - W_W'(fx);
				mul_x = X_W'(p00);
			end
			S_M1: begin
				mul_w = W_W'(fx);
				mul_x = X_W'(tr);
			end
			S_M2: begin
				mul_w = ONE_W - W_W'(fx);
				mul_x = X_W'(p10);
			end
			S_M3: begin
				mul_w = W_W'(fx);
				mul_x = X_W'(pix_q);
			end
			S_M4: begin
				mul_w = ONE_W - W_W'(fy);
				mul_x = a_q;
			end
			S_M5: begin
				mul_w = W_W'(fy);
				mul_x = b_q;
			end
			default: begin
				mul_w = '0;
				mul_x = '0;
			end
		endcase
		prod      = P_W'(mul_w) * P_W'(mul_x);
		rnd       = mac_q + HALF;
		last_pair = (({1'b0, j_q} + 2'd1) == ncol_q) && (({1'b0, i_q} + 2'd1) == nrow_q);
	end

	// sequencer and output register
	logic [PIX_W-1:0]   out_pixel_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic               out_valid_q, run_last_q, frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			src_col_q   <= '0;
			src_row_q   <= '0;
			dst_col_q   <= '0;
			dst_row_q   <= '0;
			x_accum_q   <= '0;
			y_accum_q   <= '0;
			cur_left_q  <= '0;
			pix_q       <= '0;
			c_q         <= '0;
			r_q         <= '0;
			col_last_q  <= 1'b0;
			row_last_q  <= 1'b0;
			g_acc_q     <= '0;
			g_idx_q     <= '0;
			g_n_q       <= '0;
			ncol_q      <= '0;
			nrow_q      <= '0;
			col_idx_q   <= '{default: '0};
			row_idx_q   <= '{default: '0};
			fx_q        <= '{default: '0};
			fy_q        <= '{default: '0};
			cl_q        <= '0;
			ru_q        <= '0;
			i_q         <= 1'b0;
			j_q         <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			mac_q       <= '0;
			out_valid_q <= 1'b0;
			out_pixel_q <= '0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			run_last_q  <= 1'b0;
			frame_end_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_PUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pix_q      <= src_pixel;
						c_q        <= c_comb;
						r_q        <= r_comb;
						col_last_q <= (GI_W'(c_comb) == sw_m1);
						row_last_q <= (SIZE_W'(r_comb) == sh_m1);
						g_acc_q    <= x_accum_q;
						g_idx_q    <= GI_W'(dst_col_q);
						g_n_q      <= '0;
						state_q    <= S_GX;
					end
				end
				S_GX: begin
					if (g_take) begin
						col_idx_q[g_n_q[0]] <= g_idx_q;
						fx_q[g_n_q[0]]      <= g_frac;
						cl_q[g_n_q[0]]      <= ~g_clamp;
						g_n_q               <= g_n_q + 2'd1;
						g_idx_q             <= g_idx_q + GI_W'(1);
						g_acc_q             <= g_acc_q + g_step;
					end else begin
						x_accum_q <= g_acc_q;
						dst_col_q <= g_idx_q[SZ_W-1:0];
						ncol_q    <= g_n_q;
						g_acc_q   <= y_accum_q;
						g_idx_q   <= GI_W'(dst_row_q);
						g_n_q     <= '0;
						state_q   <= S_GY;
					end
				end
				S_GY: begin
					if (g_take) begin
						row_idx_q[g_n_q[0]] <= g_idx_q;
						fy_q[g_n_q[0]]      <= g_frac;
						ru_q[g_n_q[0]]      <= ~g_clamp;
						g_n_q               <= g_n_q + 2'd1;
						g_idx_q             <= g_idx_q + GI_W'(1);
						g_acc_q             <= g_acc_q + g_step;
					end else begin
						nrow_q <= g_n_q;
						i_q    <= 1'b0;
						j_q    <= 1'b0;
						if (ncol_q == '0 || g_n_q == '0)
							state_q <= S_WB1;
						else
							state_q <= S_M0;
					end
				end
				S_M0: begin
					mac_q   <= prod[MAC_W-1:0];
					state_q <= S_M1;
				end
				S_M1: begin
					mac_q   <= mac_q + prod[MAC_W-1:0];
					state_q <= S_M2;
				end
				S_M2: begin
					a_q     <= mac_q[X_W-1:0];
					mac_q   <= prod[MAC_W-1:0];
					state_q <= S_M3;
				end
				S_M3: begin
					mac_q   <= mac_q + prod[MAC_W-1:0];
					state_q <= S_M4;
				end
				S_M4: begin
					b_q     <= mac_q[X_W-1:0];
					mac_q   <= prod[MAC_W-1:0];
					state_q <= S_M5;
				end
				S_M5: begin
					mac_q   <= mac_q + prod[MAC_W-1:0];
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_pixel_q <= rnd[MAC_W-1:2*FRAC_BITS];
						out_x_q     <= col_idx_q[j_q][COORD_W-1:0];
						out_y_q     <= row_idx_q[i_q][COORD_W-1:0];
						run_last_q  <= last_pair;
						frame_end_q <= (col_idx_q[j_q] == dw - GI_W'(1)) &&
							(row_idx_q[i_q] == GI_W'(dh) - GI_W'(1));
						if (({1'b0, j_q} + 2'd1) != ncol_q) begin
							j_q     <= 1'b1;
							state_q <= S_M0;
						end else if (({1'b0, i_q} + 2'd1) != nrow_q) begin
							i_q     <= 1'b1;
							j_q     <= 1'b0;
							state_q <= S_M0;
						end else begin
							state_q <= S_WB1;
						end
					end
				end
				S_WB1: begin
					state_q <= S_WB2;
				end
				S_WB2: begin
					cur_left_q <= pix_q;
					if (col_last_q) begin
						src_col_q <= '0;
						dst_col_q <= '0;
						x_accum_q <= '0;
						if (row_last_q) begin
							src_row_q <= '0;
							dst_row_q <= '0;
							y_accum_q <= '0;
						end else begin
							src_row_q <= r_q + ROW_W'(1);
							dst_row_q <= g_idx_q[SIZE_W-1:0];
							y_accum_q <= g_acc_q;
						end
					end else begin
						src_col_q <= c_q + IDX_W'(1);
						src_row_q <= r_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	`BIDS_ASSERT_IMPL(a_frame_end_is_last, out_valid && frame_end, run_last)
	`BIDS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`BIDS_ASSERT_IMPL(a_result_from_put, $rose(out_valid), $past(state_q == S_PUT))

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the bilinear image downscaler: predicted frames, random handshakes.
`timescale 1ns / 100ps

module tb_top import bids_pkg::*; ();

	localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS_DEF;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_BEATS = 260;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               run_last;
		logic               frame_end;
	} dst_pix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] src_pixel = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PIX_W-1:0] out_pixel;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic run_last;
	logic frame_end;

	// register shadows
	logic [SIZE_W-1:0] cfg_src_w = SRC_WIDTH_RST;
	logic [SIZE_W-1:0] cfg_src_h = SRC_HEIGHT_RST;
	logic [SIZE_W-1:0] cfg_dst_w = DST_WIDTH_RST;
	logic [SIZE_W-1:0] cfg_dst_h = DST_HEIGHT_RST;
	logic [STEP_W-1:0] cfg_x_step = X_STEP_RST;
	logic [STEP_W-1:0] cfg_y_step = Y_STEP_RST;

	// scaler state mirror
	logic [PIX_W-1:0] line_store [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] left_pix = '0;
	int unsigned s_col = 0, s_row = 0, d_col = 0, d_row = 0;
	logic [63:0] x_acc = '0, y_acc = '0;

	logic [PIX_W-1:0] src_stream [$];
	dst_pix_t expected_pixels [$];
	dst_pix_t want_pix;

	bit gaps_on = 1'b1;
	int send_gap = 0;
	int stall_left = 0;
	int err_cnt = 0;
	int beats_in = 0;
	int results_seen = 0;
	int settings_used = 0;

	bilinear_image_downscaler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.src_pixel (src_pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pixel (out_pixel),
		.out_x     (out_x),
		.out_y     (out_y),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

	always #1 clk = ~clk;

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PIX_W-1:0] draw_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned cap);
		if (v == 0) return 1;
		return (v > cap) ? cap : v;
	endfunction

	function automatic logic [63:0] eff_step(input logic [STEP_W-1:0] s);
		return (64'(s) < ONE_FX) ? ONE_FX : 64'(s);
	endfunction

	// Destination indices (at most two) whose upper source neighbour is pos.
	function automatic int unsigned gather_axis(input int unsigned start, input logic [63:0] acc,
			input logic [63:0] step, input int unsigned dsize, input int unsigned ssize,
			input int unsigned pos, output logic [1:0][31:0] idx, output logic [1:0][63:0] frac,
			output logic [1:0] low);
		int unsigned n, d, lo, hi;
		logic [63:0] ip, f, a;
		n = 0;
		d = start;
		a = acc;
		idx = '0;
		frac = '0;
		low = '0;
		while (n < 2 && d < dsize) begin
			ip = a >> FRAC_BITS_DEF;
			if (ip >= 64'(ssize - 1)) begin
				lo = ssize - 1;
				hi = ssize - 1;
				f = '0;
			end else begin
				lo = ip[31:0];
				hi = lo + 1;
				f = a & (ONE_FX - 1);
			end
			if (hi != pos) break;
			idx[n] = d;
			frac[n] = f;
			low[n] = (lo != hi);
			n++;
			d++;
			a += step;
		end
		return n;
	endfunction

	task automatic blend_source_pixel(input logic [PIX_W-1:0] pix);
		int unsigned sw, sh, dw, dh, c, r, ncol, nrow, i, j;
		logic [63:0] xs, ys, p, here_up, left_up, left_cur, tl, tr, p00, p10, fx, fy, sum, v;
		logic [1:0][31:0] cols, rows;
		logic [1:0][63:0] fxs, fys;
		logic [1:0] cl, ru;
		dst_pix_t e;
		sw = eff_size(cfg_src_w, MAX_WIDTH_DEF);
		sh = eff_size(cfg_src_h, HEIGHT_CAP);
		dw = eff_size(cfg_dst_w, MAX_WIDTH_DEF);
		dh = eff_size(cfg_dst_h, HEIGHT_CAP);
		xs = eff_step(cfg_x_step);
		ys = eff_step(cfg_y_step);
		if (dw > sw) dw = sw;
		if (dh > sh) dh = sh;
		c = (s_col < sw) ? s_col : sw - 1;
		r = (s_row < sh) ? s_row : sh - 1;
		p = {56'd0, pix};
		left_cur = (c != 0) ? {56'd0, left_pix} : p;
		here_up = (r != 0) ? {56'd0, line_store[c]} : p;
		if (c == 0) left_up = here_up;
		else if (r != 0) left_up = {56'd0, line_store[c - 1]};
		else left_up = {56'd0, left_pix};

		ncol = gather_axis(d_col, x_acc, xs, dw, sw, c, cols, fxs, cl);
		nrow = gather_axis(d_row, y_acc, ys, dh, sh, r, rows, fys, ru);

		for (i = 0; i < nrow; i++) begin
			tl = ru[i] ? left_up : left_cur;
			tr = ru[i] ? here_up : p;
			fy = fys[i];
			for (j = 0; j < ncol; j++) begin
				fx = fxs[j];
				p00 = cl[j] ? tl : tr;
				p10 = cl[j] ? left_cur : p;
				sum = (ONE_FX - fx) * (ONE_FX - fy) * p00 + fx * (ONE_FX - fy) * tr
					+ (ONE_FX - fx) * fy * p10 + fx * fy * p;
				v = (sum + (64'd1 << (2 * FRAC_BITS_DEF - 1))) >> (2 * FRAC_BITS_DEF);
				e.pixel = (v > 64'd255) ? 8'hFF : v[7:0];
				e.col = cols[j][COORD_W-1:0];
				e.row = rows[i][COORD_W-1:0];
				e.run_last = (i == nrow - 1) && (j == ncol - 1);
				e.frame_end = (cols[j] == dw - 1) && (rows[i] == dh - 1);
				expected_pixels.push_back(e);
			end
		end

		d_col += ncol;
		x_acc += 64'(ncol) * xs;
		if (c >= 1) line_store[c - 1] = left_pix;
		if (c == sw - 1) line_store[c] = pix;
		left_pix = pix;
		if (c == sw - 1) begin
			s_col = 0;
			d_col = 0;
			x_acc = '0;
			d_row += nrow;
			y_acc += 64'(nrow) * ys;
			if (r == sh - 1) begin
				s_row = 0;
				d_row = 0;
				y_acc = '0;
			end else begin
				s_row = r + 1;
			end
		end else begin
			s_col = c + 1;
			s_row = r;
		end
	endtask

	// source beat driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_pixel <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				blend_source_pixel(src_pixel);
				beats_in++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (src_stream.size() != 0) begin
					src_pixel <= src_stream.pop_front();
					in_valid <= 1'b1;
					send_gap <= gaps_on ? draw_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_pixels.size() == 0) begin
					$error("unexpected result: out_x=%0d out_y=%0d out_pixel=%0d",
						out_x, out_y, out_pixel);
					err_cnt++;
				end else begin
					want_pix = expected_pixels.pop_front();
					if (out_pixel !== want_pix.pixel) begin
						$error("out_pixel: expected %0d, got %0d", want_pix.pixel, out_pixel);
						err_cnt++;
					end
					if (out_x !== want_pix.col) begin
						$error("out_x: expected %0d, got %0d", want_pix.col, out_x);
						err_cnt++;
					end
					if (out_y !== want_pix.row) begin
						$error("out_y: expected %0d, got %0d", want_pix.row, out_y);
						err_cnt++;
					end
					if (run_last !== want_pix.run_last) begin
						$error("run_last: expected %0d, got %0d", want_pix.run_last, run_last);
						err_cnt++;
					end
					if (frame_end !== want_pix.frame_end) begin
						$error("frame_end: expected %0d, got %0d", want_pix.frame_end, frame_end);
						err_cnt++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				stall_left <= draw_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (src_stream.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] junk;
		junk = $urandom;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		if (idx == REG_X_STEP || idx == REG_Y_STEP)
			pwdata <= {junk[31:STEP_W], value[STEP_W-1:0]};
		else
			pwdata <= {junk[31:SIZE_W], value[SIZE_W-1:0]};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:  cfg_src_w = value[SIZE_W-1:0];
			REG_SRC_HEIGHT: cfg_src_h = value[SIZE_W-1:0];
			REG_DST_WIDTH:  cfg_dst_w = value[SIZE_W-1:0];
			REG_DST_HEIGHT: cfg_dst_h = value[SIZE_W-1:0];
			REG_X_STEP:     cfg_x_step = value[STEP_W-1:0];
			REG_Y_STEP:     cfg_y_step = value[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_scale(input logic [31:0] sw, input logic [31:0] sh, input logic [31:0] dw,
			input logic [31:0] dh, input logic [31:0] xs, input logic [31:0] ys);
		wait_drained();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_X_STEP, xs);
		write_reg(REG_Y_STEP, ys);
		settings_used++;
	endtask

	task automatic push_pixels(input int unsigned n);
		for (int unsigned k = 0; k < n; k++) src_stream.push_back(draw_pixel());
	endtask

	task automatic push_frames(input int unsigned n);
		push_pixels(n * eff_size(cfg_src_w, MAX_WIDTH_DEF) * eff_size(cfg_src_h, HEIGHT_CAP));
	endtask

	// Completes the frame in progress; call only once drained.
	task automatic finish_frame();
		int unsigned sw, sh, c, r;
		sw = eff_size(cfg_src_w, MAX_WIDTH_DEF);
		sh = eff_size(cfg_src_h, HEIGHT_CAP);
		c = (s_col < sw) ? s_col : sw - 1;
		r = (s_row < sh) ? s_row : sh - 1;
		if (s_col != 0 || s_row != 0) push_pixels((sw - c) + (sh - 1 - r) * sw);
	endtask

	function automatic logic [31:0] pick_step(input int unsigned s, input int unsigned d);
		int unsigned m;
		m = $urandom_range(0, 9);
		if (m < 6) return (s << FRAC_BITS_DEF) / d;
		if (m == 6) return $urandom_range(0, 32'h0000FFFF);
		if (m == 7) return $urandom_range(32'h00010000, 32'h3FFFFFFF);
		if (m == 8) return 32'h3FFFFFFF;
		return (s << FRAC_BITS_DEF) / d + $urandom_range(1, 32'h0002FFFF);
	endfunction

	initial begin
		int unsigned sw, sh, swe, she, dw, dh, frame_px, rnd_start;
		foreach (line_store[k]) line_store[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 3x3 down to 1x1
		for (int k = 0; k < 9; k++) src_stream.push_back(k[0] ? 8'hFF : 8'h00);

		// sample past the edge, clamped to the last source pixel
		set_scale(2, 2, 2, 2, 32'h18000, 32'h18000);
		src_stream.push_back(8'hFF);
		src_stream.push_back(8'h00);
		src_stream.push_back(8'h00);
		src_stream.push_back(8'hFF);

		// zero sizes and steps below one
		set_scale(0, 0, 0, 0, 0, 0);
		src_stream.push_back(8'h00);
		src_stream.push_back(8'hFF);

		// crowded right edge
		set_scale(4, 2, 4, 2, 32'h30000, 32'h10000);
		push_frames(1);

		// resize mid-frame after a full pause
		set_scale(6, 5, 3, 3, 32'h20000, 32'h1AAAA);
		push_pixels(15);
		wait_drained();
		write_reg(REG_SRC_WIDTH, 4);
		write_reg(REG_SRC_HEIGHT, 3);
		write_reg(REG_DST_HEIGHT, 2);
		finish_frame();

		// oversized registers saturate, then the frame shrinks mid-row
		gaps_on = 1'b1;
		set_scale(16383, 16383, 16383, 16383, 32'h10000, 0);
		push_pixels(10);
		wait_drained();
		write_reg(REG_SRC_WIDTH, 12);
		write_reg(REG_SRC_HEIGHT, 2);
		finish_frame();

		rnd_start = beats_in;
		while (beats_in - rnd_start < RANDOM_BEATS) begin
			sw = $urandom_range(0, 12);
			sh = $urandom_range(0, 8);
			swe = (sw == 0) ? 1 : sw;
			she = (sh == 0) ? 1 : sh;
			dw = ($urandom_range(0, 4) == 0) ? $urandom_range(swe, swe + 4)
				: $urandom_range(1, swe);
			dh = ($urandom_range(0, 4) == 0) ? $urandom_range(she, she + 4)
				: $urandom_range(1, she);
			set_scale(sw, sh, dw, dh, pick_step(swe, (dw < swe) ? dw : swe),
				pick_step(she, (dh < she) ? dh : she));
			gaps_on = ($urandom_range(0, 3) != 0);
			frame_px = swe * she;
			if ($urandom_range(0, 3) == 0) begin
				push_pixels($urandom_range(1, frame_px));
				wait_drained();
				finish_frame();
			end else begin
				push_frames($urandom_range(1, 3));
			end
			wait_drained();
		end

		wait_drained();
		$display("Checked %0d destination pixels from %0d source beats over %0d scaler settings,",
			results_seen, beats_in, settings_used);
		$display("incl. saturated sizes and steps, crowded edges and mid-frame resizes.");
		if (err_cnt == 0)
			$display("bilinear_image_downscaler test passed");
		else
			$display("bilinear_image_downscaler test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("bilinear_image_downscaler test failed");
		$finish;
	end

endmodule
